// ===== src/lpsf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the LED pixel store.
package lpsf_pkg;

    localparam int DEF_NUM_STRIPS  = 4;
    localparam int DEF_STRIP_DEPTH = 256;
    localparam int REG_STRIPS      = 4;
    localparam int START_W         = 16;
    localparam int CNT_W           = 9;
    localparam int CNT_CAP         = 256;
    localparam int COLOR_W         = 24;
    localparam int QUEUE_DEPTH     = 2;
    localparam int FADE_KNEE       = 16;
    localparam int REG_IDX_W       = 3;

    localparam logic [REG_IDX_W-1:0] REG_STRIP0_START = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STRIP1_START = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STRIP2_START = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STRIP3_START = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STRIP0_COUNT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STRIP1_COUNT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STRIP2_COUNT = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_STRIP3_COUNT = 3'd7;

    typedef enum logic [2:0] {
        REQ_SET_BLOCK  = 3'd0,
        REQ_CLEAR_ALL  = 3'd1,
        REQ_SET_ALL    = 3'd2,
        REQ_FADE_TICK  = 3'd3,
        REQ_READ_BLOCK = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_BLOCK_ZERO   = 2'd1,
        STAT_OUT_OF_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_SET,
        OP_FILL,
        OP_FADE,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_WALK,
        BS_DRAIN,
        BS_READ,
        BS_RESULT
    } t_bstate;

    typedef struct packed {
        t_op                op;
        t_status            status;
        logic [COLOR_W-1:0] color;
        logic               lights_on;
    } t_cmd;

endpackage

// ===== src/lpsf_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the LED pixel store.
interface lpsf_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [15:0] block;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        lights_on;

    modport source (output valid, req_type, block, red, green, blue, lights_on, input ready);
    modport sink (input valid, req_type, block, red, green, blue, lights_on, output ready);
endinterface

interface lpsf_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       any_lit;

    modport source (output valid, status, red_out, green_out, blue_out, any_lit, input ready);
    modport sink (input valid, status, red_out, green_out, blue_out, any_lit, output ready);
endinterface

// ===== src/lpsf_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request words, locates blocks, applies gamma, queues commands.
module lpsf_front import lpsf_pkg::*; #(
    parameter int NUM_STRIPS  = DEF_NUM_STRIPS,
    parameter int STRIP_DEPTH = DEF_STRIP_DEPTH,
    localparam int USED_STRIPS = (NUM_STRIPS < REG_STRIPS) ? NUM_STRIPS : REG_STRIPS,
    localparam int STORE_SIZE  = USED_STRIPS * STRIP_DEPTH,
    localparam int ADDR_W      = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1
) (
    lpsf_req_if.sink           i_req,
    input  logic [START_W-1:0] i_start [USED_STRIPS],
    input  logic [CNT_W-1:0]   i_used  [USED_STRIPS],
    input  logic               i_full,
    input  logic               i_clearing,
    output logic               o_push,
    output t_cmd               o_cmd,
    output logic [ADDR_W-1:0]  o_idx
);

    logic              hit;
    logic [START_W:0]  win_end;
    logic [START_W-1:0] offset;

    function automatic logic [7:0] gamma_sq(input logic [7:0] v);
        logic [15:0] p;
        logic [16:0] q;
        begin
            p = 16'(v) * 16'(v);
            q = 17'(p) + 17'(p[15:8]) + 17'd1;
            return q[15:8];
        end
    endfunction

    assign i_req.ready = !i_full && !i_clearing;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        hit     = 1'b0;
        o_idx   = '0;
        win_end = '0;
        offset  = '0;
        for (int s = USED_STRIPS - 1; s >= 0; s--) begin
            win_end = (START_W+1)'(i_start[s]) + (START_W+1)'(i_used[s]);
            if ((i_used[s] != '0) && (i_req.block >= i_start[s]) &&
                ((START_W+1)'(i_req.block) < win_end)) begin
                hit    = 1'b1;
                offset = i_req.block - i_start[s];
                o_idx  = ADDR_W'(s * STRIP_DEPTH) + ADDR_W'(offset[CNT_W-1:0]);
            end
        end
    end

    always_comb begin
        o_cmd.op        = OP_NONE;
        o_cmd.status    = STAT_OK;
        o_cmd.color     = '0;
        o_cmd.lights_on = i_req.lights_on;
        case (i_req.req_type)
            REQ_SET_BLOCK: begin
                if (i_req.block == '0) begin
                    o_cmd.status = STAT_BLOCK_ZERO;
                end else if (!hit) begin
                    o_cmd.status = STAT_OUT_OF_RANGE;
                end else begin
                    o_cmd.op    = OP_SET;
                    o_cmd.color = {gamma_sq(i_req.red), gamma_sq(i_req.green),
                                   gamma_sq(i_req.blue)};
                end
            end
            REQ_CLEAR_ALL: begin
                o_cmd.op = OP_FILL;
            end
            REQ_SET_ALL: begin
                o_cmd.op    = OP_FILL;
                o_cmd.color = {i_req.red, i_req.green, i_req.blue};
            end
            REQ_FADE_TICK: begin
                o_cmd.op = OP_FADE;
            end
            REQ_READ_BLOCK: begin
                if (i_req.block == '0) begin
                    o_cmd.status = STAT_BLOCK_ZERO;
                end else if (!hit) begin
                    o_cmd.status = STAT_OUT_OF_RANGE;
                end else begin
                    o_cmd.op = OP_READ;
                end
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

// ===== src/lpsf_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the pixel engine.
module lpsf_queue import lpsf_pkg::*; #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_QW = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [CNT_QW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_QW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== src/lpsf_back.sv =====
`timescale 1ns / 1ps
// Pixel engine: target and current stores, clearing pass, fill, fade and read.
module lpsf_back import lpsf_pkg::*; #(
    parameter int NUM_STRIPS  = DEF_NUM_STRIPS,
    parameter int STRIP_DEPTH = DEF_STRIP_DEPTH,
    localparam int USED_STRIPS = (NUM_STRIPS < REG_STRIPS) ? NUM_STRIPS : REG_STRIPS,
    localparam int STORE_SIZE  = USED_STRIPS * STRIP_DEPTH,
    localparam int ADDR_W      = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1,
    localparam int STRIP_W     = (USED_STRIPS > 1) ? $clog2(USED_STRIPS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_used [USED_STRIPS],
    input  logic              i_cmd_vld,
    input  t_cmd              i_cmd,
    input  logic [ADDR_W-1:0] i_idx,
    output logic              o_pop,
    output logic              o_clearing,
    lpsf_rsp_if.source        o_rsp
);

    t_bstate            r_state, n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [STRIP_W-1:0] r_strip, n_strip;
    logic [CNT_W-1:0]   r_pix, n_pix;
    logic [ADDR_W-1:0]  r_base, n_base;
    t_op                r_op, n_op;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_on, n_on;
    logic               r_lit, n_lit;
    logic               r_iss_vld, n_iss_vld;
    logic [ADDR_W-1:0]  r_iss_addr, n_iss_addr;
    logic               r_out_vld, n_out_vld;
    logic [1:0]         r_out_status, n_out_status;
    logic [COLOR_W-1:0] r_out_color, n_out_color;
    logic               r_out_lit, n_out_lit;

    logic [COLOR_W-1:0] r_cur_mem [STORE_SIZE];
    logic [COLOR_W-1:0] r_tgt_mem [STORE_SIZE];
    logic [COLOR_W-1:0] r_cur_rd, r_tgt_rd;

    logic               cur_we, tgt_we;
    logic [ADDR_W-1:0]  cur_waddr, tgt_waddr, rd_addr;
    logic [COLOR_W-1:0] cur_wdata, tgt_wdata;
    logic [COLOR_W-1:0] goal, fade_px;
    logic [ADDR_W+CNT_W-1:0] walk_sum;
    logic [ADDR_W-1:0]  walk_addr;
    logic               out_free;

    function automatic logic [7:0] fade_chan(input logic [7:0] c, input logic [7:0] t);
        logic [9:0] sum3;
        logic [8:0] sum2;
        begin
            sum3 = 10'(c) + 10'({t, 1'b0}) + 10'(t);
            sum2 = 9'(c) + 9'(t);
            if (c == t) begin
                return c;
            end else if (c < 8'(FADE_KNEE)) begin
                return sum3[9:2];
            end else begin
                return sum2[8:1];
            end
        end
    endfunction

    assign walk_sum  = (ADDR_W+CNT_W)'(r_base) + (ADDR_W+CNT_W)'(r_pix);
    assign walk_addr = walk_sum[ADDR_W-1:0];
    assign goal      = r_on ? r_tgt_rd : '0;
    assign fade_px   = {fade_chan(r_cur_rd[23:16], goal[23:16]),
                        fade_chan(r_cur_rd[15:8], goal[15:8]),
                        fade_chan(r_cur_rd[7:0], goal[7:0])};
    assign out_free  = !r_out_vld || o_rsp.ready;

    assign o_clearing      = (r_state == BS_CLEAR);
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.red_out   = r_out_color[23:16];
    assign o_rsp.green_out = r_out_color[15:8];
    assign o_rsp.blue_out  = r_out_color[7:0];
    assign o_rsp.any_lit   = r_out_lit;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_strip      = r_strip;
        n_pix        = r_pix;
        n_base       = r_base;
        n_op         = r_op;
        n_color      = r_color;
        n_on         = r_on;
        n_lit        = r_lit;
        n_iss_vld    = 1'b0;
        n_iss_addr   = r_iss_addr;
        n_out_vld    = r_out_vld && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_color  = r_out_color;
        n_out_lit    = r_out_lit;
        o_pop        = 1'b0;
        cur_we       = 1'b0;
        tgt_we       = 1'b0;
        cur_waddr    = r_iss_addr;
        tgt_waddr    = r_iss_addr;
        cur_wdata    = fade_px;
        tgt_wdata    = r_color;
        rd_addr      = walk_addr;

        if (r_iss_vld) begin
            if (r_op == OP_FADE) begin
                cur_we = 1'b1;
                if ((fade_px != '0) || (r_tgt_rd != '0)) begin
                    n_lit = 1'b1;
                end
            end else begin
                tgt_we = 1'b1;
            end
        end

        case (r_state)
            BS_CLEAR: begin
                cur_we    = 1'b1;
                tgt_we    = 1'b1;
                cur_waddr = r_clr_addr;
                tgt_waddr = r_clr_addr;
                cur_wdata = '0;
                tgt_wdata = '0;
                if (r_clr_addr == ADDR_W'(STORE_SIZE - 1)) begin
                    n_state = BS_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            BS_IDLE: begin
                if (i_cmd_vld && out_free) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_SET: begin
                            tgt_we       = 1'b1;
                            tgt_waddr    = i_idx;
                            tgt_wdata    = i_cmd.color;
                            n_out_vld    = 1'b1;
                            n_out_status = i_cmd.status;
                            n_out_color  = '0;
                            n_out_lit    = 1'b0;
                        end
                        OP_FILL, OP_FADE: begin
                            n_op    = i_cmd.op;
                            n_color = i_cmd.color;
                            n_on    = i_cmd.lights_on;
                            n_lit   = 1'b0;
                            n_strip = '0;
                            n_pix   = '0;
                            n_base  = '0;
                            n_state = BS_WALK;
                        end
                        OP_READ: begin
                            rd_addr = i_idx;
                            n_state = BS_READ;
                        end
                        default: begin
                            n_out_vld    = 1'b1;
                            n_out_status = i_cmd.status;
                            n_out_color  = '0;
                            n_out_lit    = 1'b0;
                        end
                    endcase
                end
            end
            BS_WALK: begin
                if (r_pix < i_used[r_strip]) begin
                    n_iss_vld  = 1'b1;
                    n_iss_addr = walk_addr;
                    n_pix      = r_pix + 1'b1;
                end else if (r_strip == STRIP_W'(USED_STRIPS - 1)) begin
                    n_state = BS_DRAIN;
                end else begin
                    n_strip = r_strip + 1'b1;
                    n_pix   = '0;
                    n_base  = r_base + ADDR_W'(STRIP_DEPTH);
                end
            end
            BS_DRAIN: begin
                n_state = BS_RESULT;
            end
            BS_READ: begin
                n_out_vld    = 1'b1;
                n_out_status = STAT_OK;
                n_out_color  = r_cur_rd;
                n_out_lit    = 1'b0;
                n_state      = BS_IDLE;
            end
            BS_RESULT: begin
                n_out_vld    = 1'b1;
                n_out_status = STAT_OK;
                n_out_color  = '0;
                n_out_lit    = r_lit;
                n_state      = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_clr_addr <= '0;
            r_iss_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_lit      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_iss_vld  <= n_iss_vld;
            r_out_vld  <= n_out_vld;
            r_lit      <= n_lit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_strip      <= n_strip;
        r_pix        <= n_pix;
        r_base       <= n_base;
        r_op         <= n_op;
        r_color      <= n_color;
        r_on         <= n_on;
        r_iss_addr   <= n_iss_addr;
        r_out_status <= n_out_status;
        r_out_color  <= n_out_color;
        r_out_lit    <= n_out_lit;
    end

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            r_cur_mem[cur_waddr] <= cur_wdata;
        end
        r_cur_rd <= r_cur_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        r_tgt_rd <= r_tgt_mem[rd_addr];
    end

endmodule

// ===== src/led_pixel_store_command_fade.sv =====
`timescale 1ns / 1ps
// Top level of the LED pixel store: strip registers, front end, queue and pixel engine.
//
//  port      | dir | kind          | carries
//  ----------+-----+---------------+-----------------------------------------------
//  i_req     | in  | valid/ready   | request word: type, block, colour, lights flag
//  o_rsp     | out | valid/ready   | response word: status, colour, any-lit flag
//  psel..    | in  | APB           | strip start and count registers
//
//  Set block and rejected requests: the response is registered at the pop.
//  Read block: the registered store read, then the registered response word.
//  Clear, set all and fade tick: BS_WALK covers the used pixels of each strip,
//  one pixel per cycle through the single store port, then BS_DRAIN and BS_RESULT.
//  After reset, clearing all STORE_SIZE entries (1024 by default) holds i_req.ready low.
//  A waiting response holds the engine; intake goes on until the two-word queue fills.
module led_pixel_store_command_fade import lpsf_pkg::*; #(
    parameter int NUM_STRIPS  = DEF_NUM_STRIPS,
    parameter int STRIP_DEPTH = DEF_STRIP_DEPTH,
    localparam int USED_STRIPS = (NUM_STRIPS < REG_STRIPS) ? NUM_STRIPS : REG_STRIPS,
    localparam int STORE_SIZE  = USED_STRIPS * STRIP_DEPTH,
    localparam int ADDR_W      = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    lpsf_req_if.sink    i_req,
    lpsf_rsp_if.source  o_rsp
);

    localparam int QDATA_W = $bits(t_cmd) + ADDR_W;
    localparam int CAP     = (STRIP_DEPTH < (2 ** CNT_W) - 1) ? STRIP_DEPTH : (2 ** CNT_W) - 1;

    logic [START_W-1:0] r_start [REG_STRIPS];
    logic [CNT_W-1:0]   r_count [REG_STRIPS];
    logic [START_W-1:0] start_used [USED_STRIPS];
    logic [CNT_W-1:0]   used [USED_STRIPS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic               cfg_wr;

    logic               f_push;
    t_cmd               f_cmd;
    logic [ADDR_W-1:0]  f_idx;
    logic               q_full, q_empty, q_pop;
    logic [QDATA_W-1:0] q_rdata;
    t_cmd               q_cmd;
    logic [ADDR_W-1:0]  q_idx;
    logic               clearing;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < REG_STRIPS; s++) begin
                r_start[s] <= '0;
                r_count[s] <= '0;
            end
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_STRIP0_START: r_start[0] <= pwdata[START_W-1:0];
                REG_STRIP1_START: r_start[1] <= pwdata[START_W-1:0];
                REG_STRIP2_START: r_start[2] <= pwdata[START_W-1:0];
                REG_STRIP3_START: r_start[3] <= pwdata[START_W-1:0];
                REG_STRIP0_COUNT: r_count[0] <= pwdata[CNT_W-1:0];
                REG_STRIP1_COUNT: r_count[1] <= pwdata[CNT_W-1:0];
                REG_STRIP2_COUNT: r_count[2] <= pwdata[CNT_W-1:0];
                REG_STRIP3_COUNT: r_count[3] <= pwdata[CNT_W-1:0];
                default: r_start[0] <= r_start[0];
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_STRIP0_START: prdata = 32'(r_start[0]);
            REG_STRIP1_START: prdata = 32'(r_start[1]);
            REG_STRIP2_START: prdata = 32'(r_start[2]);
            REG_STRIP3_START: prdata = 32'(r_start[3]);
            REG_STRIP0_COUNT: prdata = 32'(r_count[0]);
            REG_STRIP1_COUNT: prdata = 32'(r_count[1]);
            REG_STRIP2_COUNT: prdata = 32'(r_count[2]);
            REG_STRIP3_COUNT: prdata = 32'(r_count[3]);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        for (int s = 0; s < USED_STRIPS; s++) begin
            start_used[s] = r_start[s];
            used[s]       = (r_count[s] > CNT_W'(CAP)) ? CNT_W'(CAP) : r_count[s];
        end
    end

    lpsf_front #(
        .NUM_STRIPS  (NUM_STRIPS),
        .STRIP_DEPTH (STRIP_DEPTH)
    ) u_front (
        .i_req      (i_req),
        .i_start    (start_used),
        .i_used     (used),
        .i_full     (q_full),
        .i_clearing (clearing),
        .o_push     (f_push),
        .o_cmd      (f_cmd),
        .o_idx      (f_idx)
    );

    lpsf_queue #(
        .DATA_W (QDATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_cmd, f_idx}),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    assign q_cmd = q_rdata[QDATA_W-1:ADDR_W];
    assign q_idx = q_rdata[ADDR_W-1:0];

    lpsf_back #(
        .NUM_STRIPS  (NUM_STRIPS),
        .STRIP_DEPTH (STRIP_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_used     (used),
        .i_cmd_vld  (!q_empty),
        .i_cmd      (q_cmd),
        .i_idx      (q_idx),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_rsp      (o_rsp)
    );

endmodule

// ===== src/lpsf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the LED pixel store and their binding to the top level.
module lpsf_checker import lpsf_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_status,
    input logic [7:0] i_rsp_red,
    input logic [7:0] i_rsp_green,
    input logic [7:0] i_rsp_blue,
    input logic       i_rsp_lit
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_status) &&
        $stable(i_rsp_red) && $stable(i_rsp_green) && $stable(i_rsp_blue) &&
        $stable(i_rsp_lit))
        else $error("response word changed while stalled");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_req_ready)
        else $error("request taken during clearing pass");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status != 2'(STAT_OK)) |->
        (i_rsp_red == '0) && (i_rsp_green == '0) && (i_rsp_blue == '0) && !i_rsp_lit)
        else $error("rejected request returned data");

    a_lit_no_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_lit |->
        (i_rsp_red == '0) && (i_rsp_green == '0) && (i_rsp_blue == '0))
        else $error("fade response carried a colour");

endmodule

bind led_pixel_store_command_fade lpsf_checker u_lpsf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_red    (o_rsp.red_out),
    .i_rsp_green  (o_rsp.green_out),
    .i_rsp_blue   (o_rsp.blue_out),
    .i_rsp_lit    (o_rsp.any_lit)
);
